// ===== rtl/hrc_pkg.sv =====
// Shared types, constants and helpers for the RGB/HSB converter.
`timescale 1ns / 1ps
package hrc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 2;
  localparam int CH_W      = FRAC_BITS + 1;
  localparam int H6_W      = FRAC_BITS + 3;
  localparam int DIV_W     = 2 * FRAC_BITS + 5;
  localparam int NCELL     = CH_W;
  localparam logic [CH_W-1:0] ONE = CH_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] OFF_G = FRAC_BITS'((1 << FRAC_BITS) / 3);
  localparam logic [FRAC_BITS-1:0] OFF_B = FRAC_BITS'((2 << FRAC_BITS) / 3);
  localparam logic DIR_TO_HSB = 1'b0;
  localparam logic DIR_TO_RGB = 1'b1;

  typedef logic [CH_W-1:0] ch_t;
  typedef logic [DIV_W-1:0] dv_t;

  typedef struct packed {
    logic                 dir;
    logic                 grey;
    ch_t                  o1;
    ch_t                  o2;
    ch_t                  o3;
    logic [FRAC_BITS-1:0] off;
    logic                 neg;
  } pld_t;

  typedef struct packed {
    dv_t  rem_s;
    dv_t  dvs_s;
    dv_t  rem_h;
    dv_t  dvs_h;
    ch_t  q_s;
    ch_t  q_h;
    pld_t pld;
  } cell_t;

  function automatic ch_t clamp_unit(input logic [IN_W-1:0] v);
    ch_t res;
    if (v[IN_W-1]) begin
      res = '0;
    end else if (v[IN_W-2:0] > ONE) begin
      res = ONE;
    end else begin
      res = v[IN_W-2:0];
    end
    return res;
  endfunction
endpackage

// ===== rtl/hrc_front.sv =====
// Front stages: clamping, max/min search and the HSB-to-RGB products.
`timescale 1ns / 1ps
module hrc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      dir,
  input  logic [hrc_pkg::IN_W-1:0]  in_first,
  input  logic [hrc_pkg::IN_W-1:0]  in_second,
  input  logic [hrc_pkg::IN_W-1:0]  in_third,
  output logic                      out_valid,
  output hrc_pkg::cell_t            out_cell
);
  localparam int FB = hrc_pkg::FRAC_BITS;
  localparam int CW = hrc_pkg::CH_W;

  // Stage A
  hrc_pkg::ch_t r, g, b, mx, mn, a_op, b_op;
  logic [FB-1:0] off;
  logic [FB-1:0] hue;
  logic [hrc_pkg::H6_W-1:0] h6;
  logic va_r, da_r, neg_a_r;
  hrc_pkg::ch_t mx_a_r, d_a_r, mag_a_r, s_a_r, v_a_r;
  logic [FB-1:0] off_a_r;
  logic [hrc_pkg::H6_W-1:0] h6_a_r;

  always_comb begin
    r = hrc_pkg::clamp_unit(in_first);
    g = hrc_pkg::clamp_unit(in_second);
    b = hrc_pkg::clamp_unit(in_third);
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    // Red wins ties, then green.
    if (r == mx) begin
      a_op = g; b_op = b; off = '0;
    end else if (g == mx) begin
      a_op = b; b_op = r; off = hrc_pkg::OFF_G;
    end else begin
      a_op = r; b_op = g; off = hrc_pkg::OFF_B;
    end
    hue = in_first[FB-1:0];
    h6 = hrc_pkg::H6_W'(hue) * hrc_pkg::H6_W'(6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    da_r    <= dir;
    mx_a_r  <= mx;
    d_a_r   <= mx - mn;
    mag_a_r <= (a_op >= b_op) ? (a_op - b_op) : (b_op - a_op);
    neg_a_r <= (a_op < b_op);
    off_a_r <= off;
    h6_a_r  <= h6;
    s_a_r   <= hrc_pkg::clamp_unit(in_second);
    v_a_r   <= hrc_pkg::clamp_unit(in_third);
  end

  // Stage B: first round of products.
  logic [2*CW-1:0] pm, sfm, sgm;
  logic [FB-1:0] f;
  logic vb_r, db_r, neg_b_r, gry_b_r;
  hrc_pkg::ch_t mx_b_r, d_b_r, mag_b_r, p_b_r, sf_b_r, sg_b_r, v_b_r;
  logic [FB-1:0] off_b_r;
  logic [2:0] sx_b_r;

  always_comb begin
    f   = h6_a_r[FB-1:0];
    pm  = (2*CW)'(v_a_r) * (2*CW)'(hrc_pkg::ONE - s_a_r);
    sfm = (2*CW)'(s_a_r) * (2*CW)'(f);
    sgm = (2*CW)'(s_a_r) * (2*CW)'(hrc_pkg::ONE - CW'(f));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    db_r    <= da_r;
    mx_b_r  <= mx_a_r;
    d_b_r   <= d_a_r;
    mag_b_r <= mag_a_r;
    neg_b_r <= neg_a_r;
    off_b_r <= off_a_r;
    p_b_r   <= pm[FB+CW-1:FB];
    sf_b_r  <= sfm[FB+CW-1:FB];
    sg_b_r  <= sgm[FB+CW-1:FB];
    v_b_r   <= v_a_r;
    sx_b_r  <= h6_a_r[hrc_pkg::H6_W-1:FB];
    gry_b_r <= (v_a_r == '0) || (s_a_r == '0);
  end

  // Stage C: second products, sextant select and divider setup.
  logic [2*CW-1:0] qm, tm;
  hrc_pkg::ch_t q, t, p, v;
  hrc_pkg::cell_t stg;
  logic vc_r;
  hrc_pkg::cell_t cell_r;

  always_comb begin
    qm = (2*CW)'(v_b_r) * (2*CW)'(hrc_pkg::ONE - sf_b_r);
    tm = (2*CW)'(v_b_r) * (2*CW)'(hrc_pkg::ONE - sg_b_r);
    q  = qm[FB+CW-1:FB];
    t  = tm[FB+CW-1:FB];
    p  = p_b_r;
    v  = v_b_r;
    stg = '0;
    stg.pld.dir = db_r;
    stg.pld.off = off_b_r;
    stg.pld.neg = neg_b_r;
    stg.rem_s = hrc_pkg::DIV_W'(d_b_r) << FB;
    stg.dvs_s = hrc_pkg::DIV_W'(mx_b_r) << FB;
    stg.rem_h = hrc_pkg::DIV_W'(mag_b_r) << FB;
    stg.dvs_h = (hrc_pkg::DIV_W'(d_b_r) * hrc_pkg::DIV_W'(6)) << FB;
    if (db_r == hrc_pkg::DIR_TO_HSB) begin
      stg.pld.grey = (d_b_r == '0);
      stg.pld.o3   = mx_b_r;
    end else if (gry_b_r) begin
      stg.pld.grey = 1'b1;
      stg.pld.o1 = v; stg.pld.o2 = v; stg.pld.o3 = v;
    end else begin
      stg.pld.grey = 1'b0;
      case (sx_b_r)
        3'd0:    begin stg.pld.o1 = v; stg.pld.o2 = t; stg.pld.o3 = p; end
        3'd1:    begin stg.pld.o1 = q; stg.pld.o2 = v; stg.pld.o3 = p; end
        3'd2:    begin stg.pld.o1 = p; stg.pld.o2 = v; stg.pld.o3 = t; end
        3'd3:    begin stg.pld.o1 = p; stg.pld.o2 = q; stg.pld.o3 = v; end
        3'd4:    begin stg.pld.o1 = t; stg.pld.o2 = p; stg.pld.o3 = v; end
        default: begin stg.pld.o1 = v; stg.pld.o2 = p; stg.pld.o3 = q; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    cell_r <= stg;
  end

  assign out_valid = vc_r;
  assign out_cell  = cell_r;
endmodule

// ===== rtl/hrc_div_cell.sv =====
// One restoring-division cell: yields one quotient bit of each divide per word.
`timescale 1ns / 1ps
module hrc_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  hrc_pkg::cell_t in_cell,
  output logic           out_valid,
  output hrc_pkg::cell_t out_cell
);
  hrc_pkg::cell_t nxt;
  logic           valid_r;
  hrc_pkg::cell_t cell_r;

  always_comb begin
    nxt = in_cell;
    if (in_cell.rem_s >= in_cell.dvs_s) begin
      nxt.rem_s = in_cell.rem_s - in_cell.dvs_s;
      nxt.q_s   = {in_cell.q_s[hrc_pkg::CH_W-2:0], 1'b1};
    end else begin
      nxt.q_s   = {in_cell.q_s[hrc_pkg::CH_W-2:0], 1'b0};
    end
    if (in_cell.rem_h >= in_cell.dvs_h) begin
      nxt.rem_h = in_cell.rem_h - in_cell.dvs_h;
      nxt.q_h   = {in_cell.q_h[hrc_pkg::CH_W-2:0], 1'b1};
    end else begin
      nxt.q_h   = {in_cell.q_h[hrc_pkg::CH_W-2:0], 1'b0};
    end
    // The next cell tests one bit position lower.
    nxt.dvs_s = in_cell.dvs_s >> 1;
    nxt.dvs_h = in_cell.dvs_h >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    cell_r <= nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;
endmodule

// ===== rtl/rgb_hsv_converter.sv =====
// Top level of the RGB/HSB color converter.
// The block takes one word per clock and never raises busy; each result
// passes three front stages, a row of 17 division cells that each settle
// one quotient bit, and the output register. Results are strobed by
// out_valid for one cycle and cannot be held off, so the receiver must
// take every word as it appears.
`timescale 1ns / 1ps
module rgb_hsv_converter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [hrc_pkg::IN_W-1:0] in_first,
  input  logic [hrc_pkg::IN_W-1:0] in_second,
  input  logic [hrc_pkg::IN_W-1:0] in_third,
  output logic                     out_valid,
  output logic [hrc_pkg::CH_W-1:0] out_first,
  output logic [hrc_pkg::CH_W-1:0] out_second,
  output logic [hrc_pkg::CH_W-1:0] out_third,
  output logic                     out_grey_flag,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata
);
  localparam int FB = hrc_pkg::FRAC_BITS;

  logic dir_r;
  logic           vld  [0:hrc_pkg::NCELL];
  hrc_pkg::cell_t cells[0:hrc_pkg::NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= hrc_pkg::DIR_TO_HSB;
    end else if (cfg_we) begin
      dir_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  hrc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start & ~busy), .dir(dir_r),
    .in_first(in_first), .in_second(in_second), .in_third(in_third),
    .out_valid(vld[0]), .out_cell(cells[0])
  );

  for (genvar k = 0; k < hrc_pkg::NCELL; k++) begin : g_cell
    hrc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .in_valid(vld[k]), .in_cell(cells[k]),
      .out_valid(vld[k+1]), .out_cell(cells[k+1])
    );
  end

  hrc_pkg::cell_t last;
  logic [FB-1:0]  hue;
  logic           valid_r, grey_r, dir_o_r;
  hrc_pkg::ch_t   o1_r, o2_r, o3_r;

  always_comb begin
    last = cells[hrc_pkg::NCELL];
    hue  = last.pld.neg ? (last.pld.off - last.q_h[FB-1:0])
                        : (last.pld.off + last.q_h[FB-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld[hrc_pkg::NCELL];
    end
    grey_r  <= last.pld.grey;
    dir_o_r <= last.pld.dir;
    o3_r    <= last.pld.o3;
    if (last.pld.dir == hrc_pkg::DIR_TO_RGB) begin
      o1_r <= last.pld.o1;
      o2_r <= last.pld.o2;
    end else if (last.pld.grey) begin
      o1_r <= '0;
      o2_r <= '0;
    end else begin
      o1_r <= hrc_pkg::CH_W'(hue);
      o2_r <= last.q_s;
    end
  end

  assign out_valid     = valid_r;
  assign out_first     = o1_r;
  assign out_second    = o2_r;
  assign out_third     = o3_r;
  assign out_grey_flag = grey_r;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
  a_third_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_third <= hrc_pkg::ONE)
    else $error("third field above one");
  a_grey_hsb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grey_flag && (dir_o_r == hrc_pkg::DIR_TO_HSB)
      |-> out_first == '0 && out_second == '0)
    else $error("gray color with nonzero hue or saturation");
  a_grey_rgb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_grey_flag && (dir_o_r == hrc_pkg::DIR_TO_RGB)
      |-> out_first == out_third && out_second == out_third)
    else $error("gray color with unequal channels");
endmodule

// ===== tb/rgb_hsv_converter_checker.sv =====
// Checker that predicts each converted colour and compares it with the block's output.
`timescale 1ns / 1ps
module rgb_hsv_converter_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [hrc_pkg::IN_W-1:0] in_first,
  input  logic [hrc_pkg::IN_W-1:0] in_second,
  input  logic [hrc_pkg::IN_W-1:0] in_third,
  input  logic                     out_valid,
  input  logic [hrc_pkg::CH_W-1:0] out_first,
  input  logic [hrc_pkg::CH_W-1:0] out_second,
  input  logic [hrc_pkg::CH_W-1:0] out_third,
  input  logic                     out_grey_flag,
  input  logic                     cfg_we,
  input  logic                     cfg_wdata,
  output int                       fail_count,
  output int                       colors_pending
);
  typedef struct packed {
    logic [16:0] c1;
    logic [16:0] c2;
    logic [16:0] c3;
    logic        grey;
  } color_t;

  localparam longint UNIT = 64'd1 << hrc_pkg::FRAC_BITS;

  logic   dir_q;
  color_t color_q[$];

  function automatic longint unit_clamp(input logic [hrc_pkg::IN_W-1:0] v);
    longint s;
    s = $signed(v);
    if (s < 0) return 0;
    if (s > UNIT) return UNIT;
    return s;
  endfunction

  function automatic longint hue_of(input longint base, input longint a, input longint b,
                                    input longint d);
    longint mag, q;
    mag = (a >= b) ? a - b : b - a;
    q = (mag * UNIT) / (6 * d);
    return ((a >= b) ? base + q : base - q) & (UNIT - 1);
  endfunction

  function automatic color_t convert(input logic dir, input logic [hrc_pkg::IN_W-1:0] x,
                                     input logic [hrc_pkg::IN_W-1:0] y,
                                     input logic [hrc_pkg::IN_W-1:0] z);
    color_t c;
    longint r, g, b, mx, mn, d, h, s, v, h6, f, p, q, t, sx;
    if (dir == hrc_pkg::DIR_TO_HSB) begin
      r = unit_clamp(x);
      g = unit_clamp(y);
      b = unit_clamp(z);
      mx = (r > g) ? r : g;
      mn = (r < g) ? r : g;
      if (b > mx) mx = b;
      if (b < mn) mn = b;
      d = mx - mn;
      c.c3 = mx[16:0];
      if (d == 0) begin
        c.c1 = '0;
        c.c2 = '0;
        c.grey = 1'b1;
      end else begin
        c.c2 = 17'((d * UNIT) / mx);
        if (r == mx) c.c1 = 17'(hue_of(0, g, b, d));
        else if (g == mx) c.c1 = 17'(hue_of(UNIT / 3, b, r, d));
        else c.c1 = 17'(hue_of((2 * UNIT) / 3, r, g, d));
        c.grey = 1'b0;
      end
    end else begin
      h = x[hrc_pkg::FRAC_BITS-1:0];
      s = unit_clamp(y);
      v = unit_clamp(z);
      if (v == 0 || s == 0) begin
        c = '{v[16:0], v[16:0], v[16:0], 1'b1};
      end else begin
        h6 = h * 6;
        sx = h6 >> hrc_pkg::FRAC_BITS;
        f = h6 & (UNIT - 1);
        p = (v * (UNIT - s)) >> hrc_pkg::FRAC_BITS;
        q = (v * (UNIT - ((s * f) >> hrc_pkg::FRAC_BITS))) >> hrc_pkg::FRAC_BITS;
        t = (v * (UNIT - ((s * (UNIT - f)) >> hrc_pkg::FRAC_BITS))) >> hrc_pkg::FRAC_BITS;
        case (sx)
          0: c = '{v[16:0], t[16:0], p[16:0], 1'b0};
          1: c = '{q[16:0], v[16:0], p[16:0], 1'b0};
          2: c = '{p[16:0], v[16:0], t[16:0], 1'b0};
          3: c = '{p[16:0], q[16:0], v[16:0], 1'b0};
          4: c = '{t[16:0], p[16:0], v[16:0], 1'b0};
          default: c = '{v[16:0], p[16:0], q[16:0], 1'b0};
        endcase
      end
    end
    return c;
  endfunction

  always @(posedge clk) begin
    color_t want, got;
    if (!rst_n) begin
      dir_q <= hrc_pkg::DIR_TO_HSB;
      fail_count <= 0;
      color_q.delete();
      colors_pending <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_first, out_second, out_third, out_grey_flag};
        if (color_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = color_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("exp %h %h %h %b got %h %h %h %b", want.c1, want.c2, want.c3,
                       want.grey, got.c1, got.c2, got.c3, got.grey);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) color_q.push_back(convert(dir_q, in_first, in_second, in_third));
      if (cfg_we) dir_q <= cfg_wdata;
      colors_pending <= color_q.size();
    end
  end
endmodule

// ===== tb/rgb_hsv_converter_test.sv =====
// Stimulus and verdict for the RGB/HSB converter.
`timescale 1ns / 1ps
module rgb_hsv_converter_test;
  localparam int LATENCY = 21;
  localparam int LIMIT = 200000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [hrc_pkg::IN_W-1:0] in_first = '0, in_second = '0, in_third = '0;
  logic                     out_valid, out_grey_flag;
  logic [hrc_pkg::CH_W-1:0] out_first, out_second, out_third;
  logic                     cfg_we = 1'b0, cfg_wdata = 1'b0;
  int                       fail_count, colors_pending;
  int                       cycle = 0;
  int                       gap_pct = 0;

  always #5 clk = ~clk;

  rgb_hsv_converter u_top (.*);
  rgb_hsv_converter_checker u_check (.*);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("rgb_hsv_converter: mismatch");
      $finish;
    end
  end

  function automatic logic [hrc_pkg::IN_W-1:0] pick_field();
    case ($urandom_range(0, 9))
      0: return hrc_pkg::IN_W'($urandom);
      1: return hrc_pkg::IN_W'(hrc_pkg::ONE);
      2: return '0;
      3: return hrc_pkg::IN_W'($urandom_range(0, 16));
      default: return hrc_pkg::IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Offers one word and holds it until the block takes it; start stays high
  // between back-to-back words.
  task automatic send_word(input logic [hrc_pkg::IN_W-1:0] a,
                           input logic [hrc_pkg::IN_W-1:0] b,
                           input logic [hrc_pkg::IN_W-1:0] c);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_first <= a;
    in_second <= b;
    in_third <= c;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_direction(input logic d);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_words();
    send_word('0, '0, '0);
    send_word(hrc_pkg::IN_W'(hrc_pkg::ONE), hrc_pkg::IN_W'(hrc_pkg::ONE),
              hrc_pkg::IN_W'(hrc_pkg::ONE));
    send_word(18'h20000, 18'h1ffff, 18'h3ffff);
    send_word(hrc_pkg::IN_W'(hrc_pkg::ONE), '0, '0);
    send_word('0, hrc_pkg::IN_W'(hrc_pkg::ONE), '0);
    send_word('0, '0, hrc_pkg::IN_W'(hrc_pkg::ONE));
    send_word(hrc_pkg::IN_W'(hrc_pkg::ONE), hrc_pkg::IN_W'(hrc_pkg::ONE), '0);
    send_word(hrc_pkg::IN_W'(hrc_pkg::ONE), '0, hrc_pkg::IN_W'(hrc_pkg::ONE));
    send_word(hrc_pkg::IN_W'(1000), hrc_pkg::IN_W'(300), hrc_pkg::IN_W'(20000));
    send_word(18'h1ffff, 18'h20000, 18'h15555);
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_words();
    set_direction(hrc_pkg::DIR_TO_RGB);
    directed_words();
    for (int k = 0; k < 6; k++)
      send_word(hrc_pkg::IN_W'(k * 10923 + 5), hrc_pkg::IN_W'(hrc_pkg::ONE),
                hrc_pkg::IN_W'(hrc_pkg::ONE));
    send_word(18'h3ffff, hrc_pkg::IN_W'(40000), hrc_pkg::IN_W'(50000));
    for (int ph = 0; ph < 6; ph++) begin
      gap_pct = (ph < 2) ? 18 : (ph < 4) ? 49 : 0;
      set_direction(ph[0]);
      for (int n = 0; n < 255; n++) begin
        send_word(pick_field(), pick_field(), pick_field());
        if (n == 100) drain();
      end
    end
    set_direction(hrc_pkg::DIR_TO_HSB);
    send_word(hrc_pkg::IN_W'(5), hrc_pkg::IN_W'(5), hrc_pkg::IN_W'(5));
    drain();
    if (fail_count == 0) $display("rgb_hsv_converter: match");
    else $display("rgb_hsv_converter: mismatch");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/hrc_pkg.sv
rtl/hrc_front.sv
rtl/hrc_div_cell.sv
rtl/rgb_hsv_converter.sv
tb/rgb_hsv_converter_checker.sv
tb/rgb_hsv_converter_test.sv
